// ===== hdl/lprd_pkg.sv =====
// Shared types and constants for the length-prefixed record deframer.
`timescale 1ns / 1ps

package lprd_pkg;

   localparam int LEN_BITS_DEF   = 32;
   localparam int HEADER_MAX_DEF = 18;

   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_FIRST = 3'd1,
      ST_TOO_LONG  = 3'd2,
      ST_BAD_TERM  = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef enum logic [5:0] {
      PH_HSTART = 6'b000001,
      PH_HEADER = 6'b000010,
      PH_BODY   = 6'b000100,
      PH_TERM   = 6'b001000,
      PH_LF     = 6'b010000,
      PH_STUCK  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       record_end;
      status_type status;
   } rsp_type;

endpackage

// ===== hdl/lprd_ifs.sv =====
// Valid/ready channel interfaces for the deframer's byte input and result output.
`timescale 1ns / 1ps

interface lprd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface lprd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       record_end;
   logic [2:0] status;

   modport source (output valid, output out_byte, output byte_valid, output record_end,
                   output status, input ready);
   modport sink (input valid, input out_byte, input byte_valid, input record_end,
                 input status, output ready);
endinterface

// ===== hdl/lprd_parser.sv =====
// Record parser: per-byte state update and result generation.
`timescale 1ns / 1ps

module lprd_parser #(
   parameter int LEN_BITS   = lprd_pkg::LEN_BITS_DEF,
   parameter int HEADER_MAX = lprd_pkg::HEADER_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        in_byte,
   output logic              res_valid,
   output lprd_pkg::rsp_type res
);

   localparam int HC_W = $clog2(HEADER_MAX + 1);
   localparam int WW   = LEN_BITS + 4;
   localparam logic [WW-1:0] LIM_W = (WW'(1) << (LEN_BITS - 1)) - WW'(1);

   lprd_pkg::phase_type phase_ff, phase_in;
   logic [HC_W-1:0]     hc_ff, hc_in;
   logic                de_ff, de_in;
   logic [LEN_BITS-1:0] acc_ff, acc_in;
   logic [LEN_BITS-1:0] body_ff, body_in;

   logic          is_digit;
   logic [7:0]    digit_w;
   logic [3:0]    digit;
   logic [WW-1:0] acc_ext;
   logic [WW-1:0] acc_next_wide;
   logic          overflow;

   assign is_digit = (in_byte >= lprd_pkg::CH_0) && (in_byte <= lprd_pkg::CH_9);
   assign digit_w  = in_byte - lprd_pkg::CH_0;
   assign digit    = digit_w[3:0];
   assign acc_ext  = WW'(acc_ff);
   // Times ten as two shifts and an add.
   assign acc_next_wide = (acc_ext << 3) + (acc_ext << 1) + WW'(digit);
   assign overflow = acc_next_wide > LIM_W;

   always_comb begin
      phase_in  = phase_ff;
      hc_in     = hc_ff;
      de_in     = de_ff;
      acc_in    = acc_ff;
      body_in   = body_ff;
      res_valid = 1'b0;
      res       = '0;
      case (phase_ff)
         lprd_pkg::PH_HSTART: begin
            if (!is_digit) begin
               phase_in       = lprd_pkg::PH_STUCK;
               res_valid      = 1'b1;
               res.record_end = 1'b1;
               res.status     = lprd_pkg::ST_BAD_FIRST;
            end else begin
               // A single digit fits when the limit, 2^(LEN_BITS-1)-1, is at least 9; it is not checked.
               hc_in    = HC_W'(1);
               de_in    = 1'b0;
               acc_in   = LEN_BITS'(digit);
               phase_in = lprd_pkg::PH_HEADER;
            end
         end
         lprd_pkg::PH_HEADER: begin
            if (in_byte == lprd_pkg::CH_LF) begin
               body_in  = acc_ff;
               phase_in = (acc_ff == '0) ? lprd_pkg::PH_TERM : lprd_pkg::PH_BODY;
            end else if (hc_ff >= HC_W'(HEADER_MAX)) begin
               phase_in       = lprd_pkg::PH_STUCK;
               res_valid      = 1'b1;
               res.record_end = 1'b1;
               res.status     = lprd_pkg::ST_TOO_LONG;
            end else begin
               hc_in = hc_ff + HC_W'(1);
               if (!de_ff) begin
                  if (!is_digit) begin
                     de_in = 1'b1;
                  end else if (overflow) begin
                     phase_in       = lprd_pkg::PH_STUCK;
                     res_valid      = 1'b1;
                     res.record_end = 1'b1;
                     res.status     = lprd_pkg::ST_OVERFLOW;
                  end else begin
                     acc_in = acc_next_wide[LEN_BITS-1:0];
                  end
               end
            end
         end
         lprd_pkg::PH_BODY: begin
            body_in = body_ff - LEN_BITS'(1);
            if (body_ff == LEN_BITS'(1)) begin
               phase_in = lprd_pkg::PH_TERM;
            end
            res_valid      = 1'b1;
            res.out_byte   = in_byte;
            res.byte_valid = 1'b1;
         end
         lprd_pkg::PH_TERM, lprd_pkg::PH_LF: begin
            if (in_byte == lprd_pkg::CH_LF) begin
               phase_in       = lprd_pkg::PH_HSTART;
               res_valid      = 1'b1;
               res.record_end = 1'b1;
               res.status     = lprd_pkg::ST_OK;
            end else if (in_byte == lprd_pkg::CH_CR && phase_ff == lprd_pkg::PH_TERM) begin
               phase_in = lprd_pkg::PH_LF;
            end else begin
               phase_in       = lprd_pkg::PH_STUCK;
               res_valid      = 1'b1;
               res.record_end = 1'b1;
               res.status     = lprd_pkg::ST_BAD_TERM;
            end
         end
         default: begin
            phase_in = lprd_pkg::PH_STUCK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lprd_pkg::PH_HSTART;
         hc_ff    <= '0;
         de_ff    <= 1'b0;
         acc_ff   <= '0;
         body_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         hc_ff    <= hc_in;
         de_ff    <= de_in;
         acc_ff   <= acc_in;
         body_ff  <= body_in;
      end
   end

endmodule

// ===== hdl/lprd_rsp_reg.sv =====
// Output register that holds one result transaction until the sink takes it.
`timescale 1ns / 1ps

module lprd_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  lprd_pkg::rsp_type in_data,
   output logic              in_ready,
   lprd_rsp_if.source        rsp_if
);

   logic              valid_ff;
   lprd_pkg::rsp_type data_ff;

   assign in_ready = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.out_byte   = data_ff.out_byte;
   assign rsp_if.byte_valid = data_ff.byte_valid;
   assign rsp_if.record_end = data_ff.record_end;
   assign rsp_if.status     = 3'(data_ff.status);

endmodule

// ===== hdl/length_prefixed_record_deframer.sv =====
// Deframer for decimal length-prefixed records: top level.
// Datapath: a byte accepted into the input register is parsed out of it combinationally, and
// its result, if it has one, enters the output register. Throughput: one byte per cycle while
// the output register can take results; the input register refills in the cycle it drains.
// Reset (synchronous, active high) returns the parser to header start, empties both registers.
`timescale 1ns / 1ps

module length_prefixed_record_deframer #(
   parameter int LEN_BITS   = lprd_pkg::LEN_BITS_DEF,
   parameter int HEADER_MAX = lprd_pkg::HEADER_MAX_DEF
) (
   input logic        clock,
   input logic        reset,
   lprd_req_if.sink   req_if,
   lprd_rsp_if.source rsp_if
);

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              step;
   logic              out_ready;
   logic              res_valid;
   lprd_pkg::rsp_type res;

   // A byte is processed only when the output register can take its result.
   assign step         = in_valid_ff && out_ready;
   assign req_if.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.in_byte;
      end
   end

   lprd_parser #(
      .LEN_BITS   (LEN_BITS),
      .HEADER_MAX (HEADER_MAX)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .in_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   lprd_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (step && res_valid),
      .in_data  (res),
      .in_ready (out_ready),
      .rsp_if   (rsp_if)
   );

endmodule
